@@ design/rarm_pkg.sv @@
// Shared constants, node record and sequencer states for the range-assign minimum tree.
package rarm_pkg;

  localparam int RARM_LEAVES = 1024;

  localparam logic [30:0] EMPTY_MIN = 31'h7FFF_FFFF;
  localparam logic [10:0] SIZE_RESET = 11'd1024;

  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  typedef struct packed {
    logic        pend;
    logic [30:0] tag;
    logic [30:0] mn;
  } node_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ENTER,
    S_READ,
    S_PD1,
    S_PD2,
    S_PD3,
    S_RET,
    S_RESUME,
    S_FIXB,
    S_FIXC
  } state_t;

endpackage

@@ design/rarm_node_ram.sv @@
// Synchronous node store: one write port and one registered read port.
module rarm_node_ram #(
  parameter int DEPTH = 2047,
  parameter int AW    = 11
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  rarm_pkg::node_t wdata,
  input  logic [AW-1:0]  raddr,
  output rarm_pkg::node_t rdata
);
  import rarm_pkg::*;

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/range_assign_range_min_tree.sv @@
// Top level: lazy segment tree for range assign and range minimum, walked by a sequencer.
//
//  channel  ports                                         handshake
//  request  start, in_action, in_left, in_right, in_value  taken when start && !busy
//  result   out_valid, out_minimum                         one-cycle strobe, no back-pressure
//  config   cfg_we, cfg_wdata                              written when cfg_we is high
//
// Each request walks the tree depth first; each node visit reads the node through the
// registered read port, then writes back, pushes down or fixes up the child minimum,
// sharing the node store's one read port and one write port.
// An empty interval is finished without leaving idle; a query's result is registered and shown in the cycle after.
// After reset a clearing pass writes all 2*LEAVES-1 nodes of the store; busy is high meanwhile.
// The receiver cannot stall, so a result is shown once and never held.
module range_assign_range_min_tree #(
  parameter int LEAVES = rarm_pkg::RARM_LEAVES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [9:0]  in_left,
  input  logic [9:0]  in_right,
  input  logic [30:0] in_value,
  output logic        out_valid,
  output logic [30:0] out_minimum,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  import rarm_pkg::*;

  localparam int NODES = 2 * LEAVES - 1;
  localparam int VW    = $clog2(NODES);
  localparam int PW    = $clog2(LEAVES);
  localparam int NW    = $clog2(LEAVES + 1);
  localparam int SD    = PW + 1;
  localparam int IW    = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  state_t state_r, state_nxt;
  logic [10:0]   size_r;
  logic [VW-1:0] clr_r, clr_nxt;
  logic          op_r, op_nxt;
  logic [30:0]   val_r, val_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [PW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, ql_r, ql_nxt, qr_r, qr_nxt;
  logic [30:0]   ret_r, ret_nxt;
  logic [30:0]   m1_r, m1_nxt;
  node_t         node_r, node_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic          outv_r, outv_nxt;
  logic [30:0]   outm_r, outm_nxt;

  logic [VW-1:0] stk_v   [SD];
  logic [PW-1:0] stk_lo  [SD];
  logic [PW-1:0] stk_hi  [SD];
  logic [PW-1:0] stk_ql  [SD];
  logic [PW-1:0] stk_qr  [SD];
  logic [1:0]    stk_ph  [SD];
  logic [30:0]   stk_acc [SD];

  logic          push, upd_top;
  logic [IW-1:0] top_i, push_i;

  logic          we;
  logic [VW-1:0] waddr, raddr;
  node_t         wdata, rdata;

  rarm_node_ram #(.DEPTH(NODES), .AW(VW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Size in use, clamped to 1 .. LEAVES, and the request's clipped bounds.
  logic [NW-1:0] n_w;
  logic [PW-1:0] nm1_w;
  logic [31:0]   rclip_w;
  logic          req_empty;

  always_comb begin
    if (size_r == 11'd0) begin
      n_w = NW'(1);
    end else if (32'(size_r) > 32'(LEAVES)) begin
      n_w = NW'(LEAVES);
    end else begin
      n_w = NW'(size_r);
    end
    nm1_w = PW'(n_w - NW'(1));
    rclip_w = (32'(in_right) > 32'(nm1_w)) ? 32'(nm1_w) : 32'(in_right);
    req_empty = 32'(in_left) > rclip_w;
  end

  // Children of the current frame.
  logic [VW:0]   c1_w, c2_w;
  logic          c2_out;
  logic [PW:0]   sum_w;
  logic [PW-1:0] mid_w, mid1_w;
  logic [PW-1:0] ql1_w, qr1_w, ql2_w, qr2_w;
  logic          full_cov, leaf_w;

  always_comb begin
    c1_w   = {v_r, 1'b0} + (VW + 1)'(1);
    c2_w   = c1_w + (VW + 1)'(1);
    c2_out = c2_w >= (VW + 1)'(NODES);
    sum_w  = {1'b0, lo_r} + {1'b0, hi_r};
    mid_w  = sum_w[PW:1];
    mid1_w = mid_w + PW'(1);
    ql1_w  = (ql_r > lo_r) ? ql_r : lo_r;
    qr1_w  = (qr_r < mid_w) ? qr_r : mid_w;
    ql2_w  = (ql_r > mid1_w) ? ql_r : mid1_w;
    qr2_w  = (qr_r < hi_r) ? qr_r : hi_r;
    full_cov = (ql_r == lo_r) && (qr_r == hi_r);
    leaf_w   = lo_r >= hi_r;
    top_i  = IW'(sp_r - SPW'(1));
    push_i = IW'(sp_r);
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    v_nxt     = v_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ql_nxt    = ql_r;
    qr_nxt    = qr_r;
    ret_nxt   = ret_r;
    m1_nxt    = m1_r;
    node_nxt  = node_r;
    sp_nxt    = sp_r;
    outv_nxt  = 1'b0;
    outm_nxt  = outm_r;
    push      = 1'b0;
    upd_top   = 1'b0;
    we        = 1'b0;
    waddr     = v_r;
    wdata     = '{pend: 1'b0, tag: 31'd0, mn: 31'd0};
    raddr     = v_r;

    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '{pend: 1'b1, tag: 31'd0, mn: 31'd0};
        clr_nxt = clr_r + VW'(1);
        if (clr_r == VW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_empty) begin
            if (in_action == ACT_QUERY) begin
              outv_nxt = 1'b1;
              outm_nxt = EMPTY_MIN;
            end
          end else begin
            op_nxt  = in_action;
            val_nxt = in_value;
            v_nxt   = '0;
            lo_nxt  = '0;
            hi_nxt  = nm1_w;
            ql_nxt  = PW'(in_left);
            qr_nxt  = PW'(rclip_w);
            sp_nxt  = '0;
            state_nxt = S_ENTER;
          end
        end
      end
      S_ENTER: begin
        if (ql_r > qr_r) begin
          ret_nxt   = EMPTY_MIN;
          state_nxt = S_RET;
        end else if (op_r == ACT_ASSIGN && full_cov) begin
          we    = 1'b1;
          wdata = '{pend: 1'b1, tag: val_r, mn: val_r};
          state_nxt = S_RET;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        node_nxt = rdata;
        if (op_r == ACT_QUERY) begin
          if (rdata.pend || full_cov || leaf_w || c2_out) begin
            ret_nxt   = rdata.mn;
            state_nxt = S_RET;
          end else begin
            push = 1'b1;
          end
        end else if (leaf_w || c2_out) begin
          state_nxt = S_RET;
        end else if (rdata.pend) begin
          state_nxt = S_PD1;
        end else begin
          push = 1'b1;
        end
      end
      S_PD1: begin
        we    = 1'b1;
        waddr = c1_w[VW-1:0];
        wdata = '{pend: 1'b1, tag: node_r.tag, mn: node_r.tag};
        state_nxt = S_PD2;
      end
      S_PD2: begin
        we    = 1'b1;
        waddr = c2_w[VW-1:0];
        wdata = '{pend: 1'b1, tag: node_r.tag, mn: node_r.tag};
        state_nxt = S_PD3;
      end
      S_PD3: begin
        we    = 1'b1;
        wdata = '{pend: 1'b0, tag: 31'd0, mn: node_r.mn};
        push  = 1'b1;
      end
      S_RET: begin
        if (sp_r == '0) begin
          if (op_r == ACT_QUERY) begin
            outv_nxt = 1'b1;
            outm_nxt = ret_r;
          end
          state_nxt = S_IDLE;
        end else begin
          v_nxt  = stk_v[top_i];
          lo_nxt = stk_lo[top_i];
          hi_nxt = stk_hi[top_i];
          ql_nxt = stk_ql[top_i];
          qr_nxt = stk_qr[top_i];
          state_nxt = S_RESUME;
        end
      end
      S_RESUME: begin
        if (stk_ph[top_i] == PH_FIRST) begin
          upd_top = 1'b1;
          v_nxt   = c2_w[VW-1:0];
          lo_nxt  = mid1_w;
          ql_nxt  = ql2_w;
          qr_nxt  = qr2_w;
          state_nxt = S_ENTER;
        end else begin
          sp_nxt = sp_r - SPW'(1);
          if (op_r == ACT_QUERY) begin
            ret_nxt   = (stk_acc[top_i] < ret_r) ? stk_acc[top_i] : ret_r;
            state_nxt = S_RET;
          end else begin
            raddr     = c1_w[VW-1:0];
            state_nxt = S_FIXB;
          end
        end
      end
      S_FIXB: begin
        m1_nxt    = rdata.mn;
        raddr     = c2_w[VW-1:0];
        state_nxt = S_FIXC;
      end
      S_FIXC: begin
        we    = 1'b1;
        wdata = '{pend: 1'b0, tag: 31'd0, mn: (m1_r < rdata.mn) ? m1_r : rdata.mn};
        state_nxt = S_RET;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Descending into the first child saves the current node on the stack.
    if (push) begin
      sp_nxt  = sp_r + SPW'(1);
      v_nxt   = c1_w[VW-1:0];
      hi_nxt  = mid_w;
      ql_nxt  = ql1_w;
      qr_nxt  = qr1_w;
      state_nxt = S_ENTER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      sp_r    <= '0;
      outv_r  <= 1'b0;
      size_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      sp_r    <= sp_nxt;
      outv_r  <= outv_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    v_r    <= v_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    ql_r   <= ql_nxt;
    qr_r   <= qr_nxt;
    ret_r  <= ret_nxt;
    m1_r   <= m1_nxt;
    node_r <= node_nxt;
    outm_r <= outm_nxt;
    if (push) begin
      stk_v[push_i]  <= v_r;
      stk_lo[push_i] <= lo_r;
      stk_hi[push_i] <= hi_r;
      stk_ql[push_i] <= ql_r;
      stk_qr[push_i] <= qr_r;
      stk_ph[push_i] <= PH_FIRST;
    end
    if (upd_top) begin
      stk_ph[top_i]  <= PH_SECOND;
      stk_acc[top_i] <= ret_r;
    end
  end

  assign busy        = state_r != S_IDLE;
  assign out_valid   = outv_r;
  assign out_minimum = outm_r;

  // The stack is empty whenever a request may be taken.
  a_idle_stack: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> sp_r == '0)
    else $error("stack not empty while idle");

  // Results only follow the idle state or the final return.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    outv_nxt |-> (state_r == S_IDLE || (state_r == S_RET && sp_r == '0)))
    else $error("result strobe from unexpected state");

  // The node store is never written while waiting for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !we)
    else $error("node store written while idle");

  // The stack never grows past its depth.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> sp_r < SPW'(SD))
    else $error("stack overflow");

endmodule

@@ verif/tb_range_assign_range_min_tree.sv @@
// Self-checking testbench for the range-assign range-minimum segment tree.
module tb_range_assign_range_min_tree;
  import rarm_pkg::*;

  localparam int NODE_COUNT = 2 * RARM_LEAVES - 1;

  class min_tree_scoreboard;
    bit [30:0]   node_mn[NODE_COUNT];
    bit [30:0]   node_tag[NODE_COUNT];
    bit          node_pend[NODE_COUNT];
    int unsigned size_reg;
    bit [30:0]   minima_due[$];
    int          errors;

    function new();
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_mn[i] = '0;
        node_tag[i] = '0;
        node_pend[i] = 1'b1;
      end
      size_reg = 32'(SIZE_RESET);
      errors = 0;
    endfunction

    function void set_size(bit [10:0] v);
      size_reg = 32'(v);
    endfunction

    function int unsigned used_span();
      if (size_reg < 1) return 1;
      if (size_reg > RARM_LEAVES) return RARM_LEAVES;
      return size_reg;
    endfunction

    function void paint(int unsigned nd, int unsigned lo, int unsigned hi,
                        int unsigned ql, int unsigned qr, bit [30:0] val);
      int unsigned mid, c1, c2;
      if (ql > qr || nd >= NODE_COUNT) return;
      if (ql == lo && qr == hi) begin
        node_pend[nd] = 1'b1;
        node_tag[nd] = val;
        node_mn[nd] = val;
        return;
      end
      if (lo >= hi) return;
      mid = lo + (hi - lo) / 2;
      c1 = 2 * nd + 1;
      c2 = 2 * nd + 2;
      if (c2 >= NODE_COUNT) return;
      // A pending tag must reach both children before the span is split.
      if (node_pend[nd]) begin
        node_pend[c1] = 1'b1;
        node_tag[c1] = node_tag[nd];
        node_mn[c1] = node_tag[nd];
        node_pend[c2] = 1'b1;
        node_tag[c2] = node_tag[nd];
        node_mn[c2] = node_tag[nd];
        node_pend[nd] = 1'b0;
        node_tag[nd] = '0;
      end
      paint(c1, lo, mid, (ql > lo) ? ql : lo, (qr < mid) ? qr : mid, val);
      paint(c2, mid + 1, hi, (ql > mid + 1) ? ql : mid + 1, (qr < hi) ? qr : hi, val);
      node_mn[nd] = (node_mn[c1] < node_mn[c2]) ? node_mn[c1] : node_mn[c2];
    endfunction

    function bit [30:0] lowest(int unsigned nd, int unsigned lo, int unsigned hi,
                               int unsigned ql, int unsigned qr);
      int unsigned mid, c1, c2;
      bit [30:0] a, b;
      if (ql > qr || nd >= NODE_COUNT) return EMPTY_MIN;
      if (node_pend[nd] || (ql == lo && qr == hi)) return node_mn[nd];
      if (lo >= hi) return node_mn[nd];
      mid = lo + (hi - lo) / 2;
      c1 = 2 * nd + 1;
      c2 = 2 * nd + 2;
      if (c2 >= NODE_COUNT) return node_mn[nd];
      a = lowest(c1, lo, mid, (ql > lo) ? ql : lo, (qr < mid) ? qr : mid);
      b = lowest(c2, mid + 1, hi, (ql > mid + 1) ? ql : mid + 1, (qr < hi) ? qr : hi);
      return (a < b) ? a : b;
    endfunction

    function void note_request(bit act, bit [9:0] l, bit [9:0] r, bit [30:0] val);
      int unsigned n, rr;
      n = used_span();
      rr = (32'(r) > n - 1) ? n - 1 : 32'(r);
      if (act == ACT_ASSIGN) paint(0, 0, n - 1, 32'(l), rr, val);
      else minima_due.push_back(lowest(0, 0, n - 1, 32'(l), rr));
    endfunction

    function void check_result(bit [30:0] got);
      bit [30:0] want;
      if (minima_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = minima_due.pop_front();
      if (got !== want) begin
        $display("%0t: minimum expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = ACT_ASSIGN;
  logic [9:0]  in_left = '0;
  logic [9:0]  in_right = '0;
  logic [30:0] in_value = '0;
  logic        out_valid;
  logic [30:0] out_minimum;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  min_tree_scoreboard sb = new();

  range_assign_range_min_tree u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_left(in_left), .in_right(in_right), .in_value(in_value),
    .out_valid(out_valid), .out_minimum(out_minimum),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_minimum);
  end

  task automatic send(bit act, bit [9:0] l, bit [9:0] r, bit [30:0] val);
    in_action <= act;
    in_left <= l;
    in_right <= r;
    in_value <= val;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(act, l, r, val);
  endtask

  // Waits for every expected result, then lets any result-free assign still in the tree finish before going on.
  task automatic drain();
    start <= 1'b0;
    while (sb.minima_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_size(bit [10:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(v);
  endtask

  task automatic random_request(bit idling);
    int unsigned n;
    bit [9:0] l, r;
    bit [30:0] val;
    bit act;
    n = sb.used_span();
    act = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 6) begin
      l = 10'($urandom_range(0, n - 1));
      r = ($urandom_range(0, 2) == 0) ? 10'(32'(l) + $urandom_range(0, 8))
                                      : 10'($urandom_range(32'(l), n - 1));
    end else begin
      l = 10'($urandom_range(0, 1023));
      r = 10'($urandom_range(0, 1023));
    end
    case ($urandom_range(0, 9))
      0: val = 31'h7FFF_FFFF;
      1, 2, 3, 4: val = 31'($urandom_range(0, 15));
      default: val = 31'($urandom);
    endcase
    send(act, l, r, val);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    bit [10:0] sizes[10] = '{11'd1, 11'd2, 11'd1024, 11'd3, 11'd17, 11'd0,
                             11'd513, 11'd2047, 11'd5, 11'd1000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fresh tree reads as zero everywhere.
    send(ACT_QUERY, 10'd0, 10'd1023, 31'd0);
    send(ACT_QUERY, 10'd512, 10'd512, 31'd0);
    send(ACT_ASSIGN, 10'd0, 10'd1023, 31'h7FFF_FFFF);
    send(ACT_QUERY, 10'd0, 10'd1023, 31'd0);
    send(ACT_QUERY, 10'd1023, 10'd1023, 31'h7FFF_FFFF);
    send(ACT_ASSIGN, 10'd1023, 10'd1023, 31'd0);
    send(ACT_QUERY, 10'd0, 10'd1022, 31'd0);
    send(ACT_QUERY, 10'd1, 10'd1023, 31'd0);
    send(ACT_ASSIGN, 10'd300, 10'd200, 31'd5);
    send(ACT_QUERY, 10'd300, 10'd200, 31'd0);
    send(ACT_QUERY, 10'd1023, 10'd0, 31'd0);
    send(ACT_ASSIGN, 10'd100, 10'd700, 31'h2AAA_AAAA);
    send(ACT_ASSIGN, 10'd300, 10'd400, 31'h5555_5555);
    send(ACT_QUERY, 10'd250, 10'd350, 31'd0);
    send(ACT_QUERY, 10'd301, 10'd399, 31'd0);
    send(ACT_ASSIGN, 10'd0, 10'd0, 31'd7);
    send(ACT_QUERY, 10'd0, 10'd0, 31'd0);
    send(ACT_QUERY, 10'd0, 10'd99, 31'd0);
    // Pause for the tree to empty its results before carrying on.
    drain();
    send(ACT_ASSIGN, 10'd1, 10'd1022, 31'd3);
    send(ACT_QUERY, 10'd0, 10'd1023, 31'd0);

    foreach (sizes[k]) begin
      write_size(sizes[k]);
      // Reach past the end, and start beyond it, under the new size.
      send(ACT_QUERY, 10'd0, 10'd1023, 31'd0);
      send(ACT_ASSIGN, 10'd0, 10'd1023, 31'd9);
      send(ACT_QUERY, 10'd1023, 10'd1023, 31'd0);
      for (int i = 0; i < 40; i++) random_request(k < 8);
    end

    drain();
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
